FILE: rtl/pfla_pkg.sv
// Shared types, status codes and field widths for the page free list allocator.
`default_nettype none

package pfla_pkg;

    localparam int ADDR_W       = 48;
    localparam int STATUS_W     = 2;
    localparam int FREE_PAGES_W = 11;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_OUT_OF_PAGES = 2'd1,
        ST_BAD_ADDRESS  = 2'd2,
        ST_LIST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic rd;
        logic accept;
        logic exec;
        logic link;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic need_link;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/pfla_ctrl.sv
// Controller state machine that sequences clearing, request execution and list linking.
`default_nettype none

module pfla_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    input  wire pfla_pkg::t_sts i_sts,
    output pfla_pkg::t_cmd      o_cmd,
    output logic                o_req_stall
);
    import pfla_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.need_link ? S_LINK : S_IDLE;
                end
            end
            S_LINK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_req_stall  = 1'b0;
                o_cmd.rd     = 1'b1;
                o_cmd.accept = i_req_valid;
            end
            S_EXEC: begin
                o_cmd.exec = i_sts.out_free;
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_exec_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> i_sts.out_free)
        else $error("Request executed while the response register was busy.");

    a_link_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LINK |=> r_state == S_IDLE)
        else $error("Link step did not return to idle.");

    a_clear_runs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && !i_sts.clr_last) |=> r_state == S_CLEAR)
        else $error("Clearing pass ended early.");

endmodule

`default_nettype wire

FILE: rtl/pfla_dp.sv
// Datapath with the successor memory, head and count registers, and response register.
`default_nettype none

module pfla_dp #(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_SHIFT = 12
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pfla_pkg::t_cmd                     i_cmd,
    output pfla_pkg::t_sts                          o_sts,
    input  wire logic                               i_cfg_we,
    input  wire logic [pfla_pkg::ADDR_W-1:0]        i_cfg_data,
    input  wire logic                               i_action,
    input  wire logic [pfla_pkg::ADDR_W-1:0]        i_page_address,
    output logic                                    o_rsp_valid,
    input  wire logic                               i_rsp_stall,
    output logic [pfla_pkg::ADDR_W-1:0]             o_granted_address,
    output logic [pfla_pkg::STATUS_W-1:0]           o_status,
    output logic [pfla_pkg::FREE_PAGES_W-1:0]       o_free_pages
);
    import pfla_pkg::*;

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int CNT_W = $clog2(NUM_PAGES + 1);
    localparam int PN_W  = ADDR_W - PAGE_SHIFT;

    logic [IDX_W-1:0] mem [NUM_PAGES];

    logic [ADDR_W-1:0] r_base;
    logic              r_action;
    logic [ADDR_W-1:0] r_addr;
    logic [IDX_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_rd;
    logic [IDX_W-1:0]  r_clr;
    logic [IDX_W-1:0]  r_link_p;

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_granted;
    t_status           r_out_status;
    logic [CNT_W-1:0]  r_out_count;

    logic [IDX_W-1:0]  n_head;
    logic [CNT_W-1:0]  n_count;
    logic [ADDR_W-1:0] n_granted;
    t_status           n_status;

    logic [ADDR_W:0]   diff;
    logic [ADDR_W-1:0] head_off;
    logic [IDX_W-1:0]  page_idx;
    logic              bad;
    logic              full;
    logic              empty;
    logic              clr_last;
    logic              out_free;
    logic              need_link;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [IDX_W-1:0]  mem_wd;

    assign diff     = {1'b0, r_addr} - {1'b0, r_base};
    assign page_idx = diff[PAGE_SHIFT +: IDX_W];
    assign bad      = diff[ADDR_W]
                   || (diff[ADDR_W-1:PAGE_SHIFT] >= PN_W'(NUM_PAGES))
                   || (r_addr[PAGE_SHIFT-1:0] != '0);
    assign full     = r_count == CNT_W'(NUM_PAGES);
    assign empty    = r_count == '0;
    assign head_off = ADDR_W'(r_head) << PAGE_SHIFT;
    assign clr_last = r_clr == IDX_W'(NUM_PAGES - 1);
    assign out_free = !r_out_valid || !i_rsp_stall;
    assign need_link = r_action && !bad && !full && !empty;

    assign o_sts.clr_last  = clr_last;
    assign o_sts.need_link = need_link;
    assign o_sts.out_free  = out_free;

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_granted = '0;
        n_status  = ST_OK;
        if (!r_action) begin
            if (empty) begin
                n_status = ST_OUT_OF_PAGES;
            end else begin
                n_granted = r_base + head_off;
                n_head    = r_rd;
                n_count   = r_count - CNT_W'(1);
            end
        end else if (bad) begin
            n_status = ST_BAD_ADDRESS;
        end else if (full) begin
            n_status = ST_LIST_FULL;
        end else begin
            n_count = r_count + CNT_W'(1);
            if (empty) begin
                n_head = page_idx;
            end
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = clr_last ? '0 : IDX_W'(r_clr + IDX_W'(1));
        if (i_cmd.clr_step) begin
            mem_we = 1'b1;
        end else if (i_cmd.exec && need_link) begin
            mem_we = 1'b1;
            mem_wa = page_idx;
            mem_wd = r_rd;
        end else if (i_cmd.link) begin
            mem_we = 1'b1;
            mem_wa = r_head;
            mem_wd = r_link_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_head      <= '0;
            r_count     <= CNT_W'(NUM_PAGES);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (i_cmd.clr_step && !clr_last) begin
                r_clr <= IDX_W'(r_clr + IDX_W'(1));
            end
            if (i_cmd.exec) begin
                r_head      <= n_head;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_addr   <= i_page_address;
        end
        if (i_cmd.exec) begin
            r_link_p      <= page_idx;
            r_out_granted <= n_granted;
            r_out_status  <= n_status;
            r_out_count   <= n_count;
        end
    end

    assign o_rsp_valid       = r_out_valid;
    assign o_granted_address = r_out_granted;
    assign o_status          = r_out_status;
    assign o_free_pages      = FREE_PAGES_W'(r_out_count);

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_PAGES))
        else $error("Free page count exceeds the region size.");

    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < IDX_W'(NUM_PAGES - 1) || r_head == IDX_W'(NUM_PAGES - 1))
        else $error("Head index lies outside the region.");

    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_status != ST_OK) |-> o_granted_address == '0)
        else $error("Failed request carries a nonzero granted address.");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_status == ST_OUT_OF_PAGES) |-> r_out_count == '0)
        else $error("Out of pages reported with free pages left.");

endmodule

`default_nettype wire

FILE: rtl/page_free_list_allocator.sv
// Top level of the page free list allocator: controller and datapath.
`default_nettype none

// Allocates and frees pages of 2**PAGE_SHIFT bytes from a region of NUM_PAGES pages
// starting at region_base, keeping a singly linked free list in an on-chip memory.
// After reset the block runs a clearing pass that builds the ascending list; requests
// are stalled during it while configuration writes are taken. An allocate, a free
// into an empty list, or any request that fails its checks, passes through the head
// successor read and then execute; a successful free into a non-empty list adds a
// link step, because the two link updates share the memory's single write port.
// Each request returns one response with the granted address, a status and the free
// page count; the response register lets the next request start while it waits.
module page_free_list_allocator #(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_SHIFT = 12
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [pfla_pkg::ADDR_W-1:0]        i_cfg_data,
    input  wire logic                               i_req_valid,
    output logic                                    o_req_stall,
    input  wire logic                               i_action,
    input  wire logic [pfla_pkg::ADDR_W-1:0]        i_page_address,
    output logic                                    o_rsp_valid,
    input  wire logic                               i_rsp_stall,
    output logic [pfla_pkg::ADDR_W-1:0]             o_granted_address,
    output logic [pfla_pkg::STATUS_W-1:0]           o_status,
    output logic [pfla_pkg::FREE_PAGES_W-1:0]       o_free_pages
);
    import pfla_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_req_stall (o_req_stall)
    );

    pfla_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_page_address    (i_page_address),
        .o_rsp_valid       (o_rsp_valid),
        .i_rsp_stall       (i_rsp_stall),
        .o_granted_address (o_granted_address),
        .o_status          (o_status),
        .o_free_pages      (o_free_pages)
    );

endmodule

`default_nettype wire
